// ===== sv/sspc_pkg.sv =====
// Shared constants, codes and types for the servo slew position controller.
package sspc_pkg;

    localparam int ANGLE_W   = 8;
    localparam int PULSE_W   = 12;
    localparam int TIME_W    = 32;
    localparam int ELAPSED_W = 16;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int DIV_DVD_W = 32;
    localparam int DIV_DSR_W = 8;
    localparam int DIV_CNT_W = $clog2(DIV_DVD_W);

    // x/180 = (x>>2)/45; ceil(2^24/45) is exact for x>>2 below 2^18
    localparam int SCALE_IN_W  = 18;
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 24;
    localparam int SCALE_Q_W   = 13;
    localparam logic [RECIP_W-1:0] SPAN_RECIP = 19'd372828;

    localparam logic [MODE_W-1:0] MODE_JUMP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TIME = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RATE = 2'd2;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_SET  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_HIGH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_TIME  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TIME = 3'd7;

    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -8'sd90;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 8'sd90;
    localparam logic signed [ANGLE_W:0]   ANGLE_OFFSET = 9'sd90;
    localparam logic [PULSE_W-1:0]        PULSE_LOW_RST  = 12'd150;
    localparam logic [PULSE_W-1:0]        PULSE_HIGH_RST = 12'd600;
    localparam logic [TIME_W-1:0]         TOTAL_TIME_RST  = 32'd1000;
    localparam logic [TIME_W-1:0]         STEP_TIME_RST   = 32'd20;
    localparam logic [TIME_W-1:0]         SETTLE_TIME_RST = 32'd500;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== sv/sspc_div.sv =====
// Radix-2 restoring divider, 32-bit dividend by 8-bit divisor, one bit per cycle.
module sspc_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [sspc_pkg::DIV_DVD_W-1:0]  dividend,
    input  logic [sspc_pkg::DIV_DSR_W-1:0]  divisor,
    output sspc_pkg::div_stat_t             stat,
    output logic [sspc_pkg::DIV_DVD_W-1:0]  quotient
);
    import sspc_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_DVD_W-1:0] work_reg, work_next;
    logic [DIV_DSR_W-1:0] rem_reg, rem_next;
    logic [DIV_DSR_W-1:0] dsr_reg, dsr_next;
    logic [DIV_DSR_W:0]   trial;
    logic [DIV_DSR_W:0]   diff;
    logic                 ge;

    assign trial = {rem_reg, work_reg[DIV_DVD_W-1]};
    assign ge    = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_DVD_W - 1);
            work_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[DIV_DSR_W-1:0] : trial[DIV_DSR_W-1:0];
            work_next = {work_reg[DIV_DVD_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = work_reg;

endmodule

// ===== sv/servo_slew_position_controller_unit.sv =====
// Servo slew position controller: tick and set-position beats in, one status beat out per item.
//
// One input beat is taken at a time; s_ready is high only while the sequencer is idle.
// A beat that writes no pulse value passes the idle, execute and done steps before its
// status beat is loaded into the output register. A beat that writes a pulse value adds
// the steps for the angle-by-span product, the scaling by 1/180 through a reciprocal
// multiply, and the offset with saturation. A set-position beat in constant-time mode
// runs the bit-serial divider for the move time over the distance and then takes the
// quotient, which is the worst item.
// A status beat that is not taken holds the done step until m_ready; a finished beat
// waits in the output register while the next input beat is accepted.
module servo_slew_position_controller_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_func,
    input  logic [sspc_pkg::ELAPSED_W-1:0]        s_elapsed_time,
    input  logic signed [sspc_pkg::ANGLE_W-1:0]   s_target_angle_in,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_pulse_write,
    output logic [sspc_pkg::PULSE_W-1:0]          m_pulse_value,
    output logic signed [sspc_pkg::ANGLE_W-1:0]   m_current_position,
    output logic                                  m_moving_flag,
    output logic                                  m_move_started,
    output logic                                  m_move_stopped,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sspc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sspc_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import sspc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_DIVT  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_SCALE = 3'd4;
    localparam logic [2:0] S_MAP   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // configuration
    logic [MODE_W-1:0]         mode_reg;
    logic signed [ANGLE_W-1:0] ang_lo_reg;
    logic signed [ANGLE_W-1:0] ang_hi_reg;
    logic [PULSE_W-1:0]        pls_lo_reg;
    logic [PULSE_W-1:0]        pls_hi_reg;
    logic [TIME_W-1:0]         total_reg;
    logic [TIME_W-1:0]         step_time_reg;
    logic [TIME_W-1:0]         settle_reg;

    // controller state
    logic [2:0]                state_reg;
    logic signed [ANGLE_W-1:0] present_reg;
    logic signed [ANGLE_W-1:0] goal_reg;
    logic                      motion_reg;
    logic [TIME_W-1:0]         acc_reg;
    logic [TIME_W-1:0]         interval_reg;

    // item latch and per-item flags
    logic                      func_reg;
    logic [ELAPSED_W-1:0]      elapsed_reg;
    logic signed [ANGLE_W-1:0] target_reg;
    logic                      wr_reg;
    logic                      started_reg;
    logic                      stopped_reg;
    logic [PULSE_W-1:0]        pv_reg;
    logic signed [21:0]        prod_reg;
    logic [SCALE_Q_W-1:0]      quo_reg;

    // output register
    logic                      m_valid_reg;
    logic                      o_wr_reg;
    logic [PULSE_W-1:0]        o_pv_reg;
    logic signed [ANGLE_W-1:0] o_pos_reg;
    logic                      o_motion_reg;
    logic                      o_started_reg;
    logic                      o_stopped_reg;

    // execute-step next values
    logic signed [ANGLE_W-1:0] ex_present;
    logic signed [ANGLE_W-1:0] ex_goal;
    logic                      ex_motion;
    logic [TIME_W-1:0]         ex_acc;
    logic [TIME_W-1:0]         ex_interval;
    logic                      ex_started;
    logic                      ex_stopped;
    logic                      ex_pulse;
    logic                      ex_div;

    logic [TIME_W:0]           acc_sum;
    logic [TIME_W-1:0]         acc_sat;
    logic signed [ANGLE_W:0]   dist_s;
    logic [ANGLE_W-1:0]        dist_abs;
    logic signed [ANGLE_W-1:0] step_ang;

    logic signed [ANGLE_W-1:0] clamp_lo;
    logic signed [ANGLE_W-1:0] clamp_ang;
    logic signed [ANGLE_W:0]   ang_off;
    logic signed [PULSE_W:0]   pls_span;
    logic signed [21:0]        prod;
    logic [21:0]               prod_abs;
    logic [SCALE_IN_W-1:0]     scale_in;
    logic [SCALE_IN_W+RECIP_W-1:0] scaled;
    logic signed [15:0]        q16;
    logic signed [15:0]        lo16;
    logic signed [15:0]        pls_sum;
    logic [PULSE_W-1:0]        pls_sat;

    logic                      div_start;
    div_stat_t                 div_stat;
    logic [DIV_DVD_W-1:0]      div_quo;
    logic                      out_load;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_JUMP;
            ang_lo_reg    <= ANGLE_MIN;
            ang_hi_reg    <= ANGLE_MAX;
            pls_lo_reg    <= PULSE_LOW_RST;
            pls_hi_reg    <= PULSE_HIGH_RST;
            total_reg     <= TOTAL_TIME_RST;
            step_time_reg <= STEP_TIME_RST;
            settle_reg    <= SETTLE_TIME_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MOVE_MODE:   mode_reg      <= cfg_data[MODE_W-1:0];
                CFG_ANGLE_LOW:   ang_lo_reg    <= cfg_data[ANGLE_W-1:0];
                CFG_ANGLE_HIGH:  ang_hi_reg    <= cfg_data[ANGLE_W-1:0];
                CFG_PULSE_LOW:   pls_lo_reg    <= cfg_data[PULSE_W-1:0];
                CFG_PULSE_HIGH:  pls_hi_reg    <= cfg_data[PULSE_W-1:0];
                CFG_TOTAL_TIME:  total_reg     <= cfg_data[TIME_W-1:0];
                CFG_STEP_TIME:   step_time_reg <= cfg_data[TIME_W-1:0];
                CFG_SETTLE_TIME: settle_reg    <= cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // tick and set-position decisions
    assign acc_sum  = {1'b0, acc_reg} + {{(TIME_W + 1 - ELAPSED_W){1'b0}}, elapsed_reg};
    assign acc_sat  = acc_sum[TIME_W] ? '1 : acc_sum[TIME_W-1:0];
    assign dist_s   = target_reg - present_reg;
    assign dist_abs = dist_s[ANGLE_W] ? ANGLE_W'(-dist_s) : dist_s[ANGLE_W-1:0];
    assign step_ang = (present_reg < goal_reg) ? present_reg + 8'sd1 : present_reg - 8'sd1;

    always_comb begin
        ex_present  = present_reg;
        ex_goal     = goal_reg;
        ex_motion   = motion_reg;
        ex_acc      = acc_reg;
        ex_interval = interval_reg;
        ex_started  = 1'b0;
        ex_stopped  = 1'b0;
        ex_pulse    = 1'b0;
        ex_div      = 1'b0;
        if (func_reg == FUNC_SET) begin
            if (mode_reg == MODE_JUMP) begin
                ex_present = target_reg;
                ex_motion  = 1'b1;
                ex_acc     = '0;
                ex_started = 1'b1;
                ex_pulse   = 1'b1;
            end else if (mode_reg == MODE_TIME || mode_reg == MODE_RATE) begin
                ex_goal    = target_reg;
                ex_started = 1'b1;
                if (target_reg == present_reg) begin
                    ex_motion  = 1'b0;
                    ex_stopped = 1'b1;
                end else begin
                    ex_motion = 1'b1;
                    ex_acc    = '0;
                    if (mode_reg == MODE_TIME) begin
                        ex_div = 1'b1;
                    end else begin
                        ex_interval = step_time_reg;
                    end
                end
            end
        end else if (motion_reg) begin
            if (mode_reg == MODE_JUMP) begin
                ex_acc = acc_sat;
                if (acc_sat >= settle_reg) begin
                    ex_motion  = 1'b0;
                    ex_stopped = 1'b1;
                end
            end else if (mode_reg == MODE_TIME || mode_reg == MODE_RATE) begin
                ex_acc = acc_sat;
                if (acc_sat >= interval_reg) begin
                    ex_acc = '0;
                    if (present_reg != goal_reg) begin
                        ex_present = step_ang;
                        ex_pulse   = 1'b1;
                    end
                end
                if (ex_present == goal_reg) begin
                    ex_motion  = 1'b0;
                    ex_stopped = 1'b1;
                end
            end
        end
    end

    // angle to pulse mapping
    assign clamp_lo  = (present_reg < ang_lo_reg) ? ang_lo_reg : present_reg;
    assign clamp_ang = (clamp_lo > ang_hi_reg) ? ang_hi_reg : clamp_lo;
    assign ang_off   = {clamp_ang[ANGLE_W-1], clamp_ang} + ANGLE_OFFSET;
    assign pls_span  = $signed({1'b0, pls_hi_reg}) - $signed({1'b0, pls_lo_reg});
    assign prod      = ang_off * pls_span;
    assign prod_abs  = prod_reg[21] ? 22'(-prod_reg) : prod_reg;
    assign scale_in  = prod_abs[SCALE_IN_W+1:2];
    assign scaled    = scale_in * SPAN_RECIP;
    assign q16       = $signed({{(16 - SCALE_Q_W){1'b0}}, quo_reg});
    assign lo16      = $signed({4'b0000, pls_lo_reg});
    assign pls_sum   = prod_reg[21] ? lo16 - q16 : lo16 + q16;
    assign pls_sat   = pls_sum[15] ? '0 : (pls_sum > 16'sd4095 ? '1 : pls_sum[PULSE_W-1:0]);

    // move time over distance
    assign div_start = (state_reg == S_EXEC) && ex_div;

    sspc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (total_reg),
        .divisor  (dist_abs),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            present_reg  <= '0;
            goal_reg     <= '0;
            motion_reg   <= 1'b0;
            acc_reg      <= '0;
            interval_reg <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    present_reg  <= ex_present;
                    goal_reg     <= ex_goal;
                    motion_reg   <= ex_motion;
                    acc_reg      <= ex_acc;
                    interval_reg <= ex_interval;
                    if (ex_div) begin
                        state_reg <= S_DIVT;
                    end else if (ex_pulse) begin
                        state_reg <= S_MUL;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_DIVT: begin
                    if (div_stat.done) begin
                        interval_reg <= div_quo;
                        state_reg    <= S_DONE;
                    end
                end
                S_MUL:   state_reg <= S_SCALE;
                S_SCALE: state_reg <= S_MAP;
                S_MAP:   state_reg <= S_DONE;
                S_DONE: begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg    <= s_func;
            elapsed_reg <= s_elapsed_time;
            target_reg  <= s_target_angle_in;
        end
        if (state_reg == S_EXEC) begin
            wr_reg      <= ex_pulse;
            started_reg <= ex_started;
            stopped_reg <= ex_stopped;
            pv_reg      <= '0;
        end
        if (state_reg == S_MUL) begin
            prod_reg <= prod;
        end
        if (state_reg == S_SCALE) begin
            quo_reg <= scaled[RECIP_SHIFT +: SCALE_Q_W];
        end
        if (state_reg == S_MAP) begin
            pv_reg <= pls_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load) begin
            o_wr_reg      <= wr_reg;
            o_pv_reg      <= pv_reg;
            o_pos_reg     <= present_reg;
            o_motion_reg  <= motion_reg;
            o_started_reg <= started_reg;
            o_stopped_reg <= stopped_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_pulse_write      = o_wr_reg;
    assign m_pulse_value      = o_pv_reg;
    assign m_current_position = o_pos_reg;
    assign m_moving_flag      = o_motion_reg;
    assign m_move_started     = o_started_reg;
    assign m_move_stopped     = o_stopped_reg;

    assert property (@(posedge aclk) disable iff (!aresetn) div_stat.busy |-> !s_ready)
        else $error("input accepted while divider busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == S_DIVT))
        else $error("divider finished outside the interval divide");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_pulse_write |-> m_pulse_value == '0)
        else $error("pulse value without pulse write");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_move_stopped |-> !m_moving_flag)
        else $error("stopped beat still flags motion");

endmodule
